/* sv/h264nal_pkg.sv */
// Package for the H.264 Annex B start-code splitter.
// Holds the parse phase type, error codes, prefix lengths and the result record.
// No dependencies.
package h264nal_pkg;

   localparam int unsigned BUFFER_BYTES_DEFAULT = 65536;

   localparam logic [2:0] PREFIX_NONE  = 3'd0;
   localparam logic [2:0] PREFIX_SHORT = 3'd3;
   localparam logic [2:0] PREFIX_LONG  = 3'd4;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_OPENING  = 2'd1,
      ERR_TOO_LONG = 2'd2
   } error_kind_type;

   typedef enum logic [1:0] {
      PH_OPEN = 2'd0,   // seeking the opening start code
      PH_HEAD = 2'd1,   // next byte is the unit header
      PH_BODY = 2'd2,   // inside a unit
      PH_DROP = 2'd3    // discard up to the last byte
   } phase_type;

   typedef struct packed {
      logic [15:0]    unit_offset;
      logic [15:0]    unit_length;
      logic [2:0]     prefix_length;
      logic           zero_bit;
      logic [1:0]     ref_idc;
      logic [4:0]     unit_type;
      error_kind_type error_kind;
      logic           end_of_buffer;
   } rsp_type;

endpackage

/* sv/h264_annexb_nal_splitter.sv */
// A result is registered: it appears on rsp_* in the cycle after the byte that closes its unit.
// Throughput: one byte per cycle; the input stalls only while a result is held
// by rsp_stall, since the single result register parts the two channels.
// Reset (synchronous, active high) clears the parse state and the result valid;
// after the byte marked last the parse state returns to its reset values on its own.
// Depends on h264nal_pkg.
module h264_annexb_nal_splitter #(
   parameter int unsigned BUFFER_BYTES = h264nal_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // byte input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // unit report channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_unit_offset,
   output logic [15:0] rsp_unit_length,
   output logic [2:0]  rsp_prefix_length,
   output logic        rsp_zero_bit,
   output logic [1:0]  rsp_ref_idc,
   output logic [4:0]  rsp_unit_type,
   output logic [1:0]  rsp_error_kind,
   output logic        rsp_end_of_buffer
);

   // Position counts up to BUFFER_BYTES itself, so it needs one bit past the index width.
   localparam int unsigned PW = $clog2(BUFFER_BYTES) + 1;
   localparam logic [PW-1:0] POS_LIMIT = PW'(BUFFER_BYTES);

   // ---------------------------------------------------------------
   // Parse state
   // ---------------------------------------------------------------
   logic [23:0]            window_ff,  window_in;   // last three bytes, oldest on top
   logic [PW-1:0]          pos_ff,     pos_in;      // position of the next byte
   logic [PW-1:0]          start_ff,   start_in;    // position of the unit header byte
   logic [2:0]             prefix_ff,  prefix_in;
   logic [7:0]             header_ff,  header_in;
   h264nal_pkg::phase_type phase_ff,   phase_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   h264nal_pkg::rsp_type   rsp_ff,       rsp_in;

   logic                   req_xfer;
   logic                   fire;        // this byte closes a unit or raises an error
   h264nal_pkg::rsp_type   result;

   // Hold the input only while a finished result waits to be taken.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;

   // ---------------------------------------------------------------
   // Per-byte parse step
   // ---------------------------------------------------------------
   logic [7:0]  b3, b2, b1, d;
   logic [31:0] q32, start32, code_at32;
   logic        zero_pair, sc3, sc4;

   always_comb begin
      b3      = window_ff[23:16];
      b2      = window_ff[15:8];
      b1      = window_ff[7:0];
      d       = req_data_byte;
      q32     = 32'(pos_ff);
      start32 = 32'(start_ff);

      zero_pair = (b2 == 8'h00) && (b1 == 8'h00) && (d == 8'h01);
      sc3       = (q32 >= start32 + 32'd3) && zero_pair;
      sc4       = sc3 && (q32 >= start32 + 32'd4) && (b3 == 8'h00);
      code_at32 = sc4 ? (q32 - 32'd3) : (q32 - 32'd2);

      window_in = window_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      prefix_in = prefix_ff;
      header_in = header_ff;
      phase_in  = phase_ff;

      fire                 = 1'b0;
      result.unit_offset   = 16'(start_ff);
      result.unit_length   = 16'd0;
      result.prefix_length = prefix_ff;
      result.zero_bit      = header_ff[7];
      result.ref_idc       = header_ff[6:5];
      result.unit_type     = header_ff[4:0];
      result.error_kind    = h264nal_pkg::ERR_NONE;
      result.end_of_buffer = req_last_byte;

      if (phase_ff == h264nal_pkg::PH_DROP) begin
         // discard
      end else if (pos_ff >= POS_LIMIT) begin
         // overrun: drop the open unit and the rest of the buffer
         fire     = 1'b1;
         phase_in = h264nal_pkg::PH_DROP;
         result   = '0;
         result.error_kind    = h264nal_pkg::ERR_TOO_LONG;
         result.end_of_buffer = 1'b1;
      end else begin
         case (phase_ff)
            h264nal_pkg::PH_OPEN: begin
               if ((q32 == 32'd2) && zero_pair) begin
                  start_in  = PW'(3);
                  prefix_in = h264nal_pkg::PREFIX_SHORT;
                  phase_in  = h264nal_pkg::PH_HEAD;
               end else if (q32 >= 32'd3) begin
                  if ((b3 == 8'h00) && zero_pair) begin
                     start_in  = PW'(4);
                     prefix_in = h264nal_pkg::PREFIX_LONG;
                     phase_in  = h264nal_pkg::PH_HEAD;
                  end else begin
                     fire     = 1'b1;
                     phase_in = h264nal_pkg::PH_DROP;
                     result   = '0;
                     result.error_kind    = h264nal_pkg::ERR_OPENING;
                     result.end_of_buffer = 1'b1;
                  end
               end
            end
            h264nal_pkg::PH_HEAD: begin
               header_in = d;
               if (req_last_byte) begin
                  // one-byte unit closed by the end of the buffer
                  fire                 = 1'b1;
                  result.unit_length   = 16'd1;
                  result.zero_bit      = d[7];
                  result.ref_idc       = d[6:5];
                  result.unit_type     = d[4:0];
                  result.end_of_buffer = 1'b1;
               end else begin
                  phase_in = h264nal_pkg::PH_BODY;
               end
            end
            h264nal_pkg::PH_BODY: begin
               if (sc3) begin
                  fire               = 1'b1;
                  result.unit_length = 16'(code_at32 - start32);
                  start_in  = PW'(q32 + 32'd1);
                  prefix_in = sc4 ? h264nal_pkg::PREFIX_LONG : h264nal_pkg::PREFIX_SHORT;
                  phase_in  = h264nal_pkg::PH_HEAD;
               end else if (req_last_byte) begin
                  fire                 = 1'b1;
                  result.unit_length   = 16'(q32 + 32'd1 - start32);
                  result.end_of_buffer = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // advance the window and the position
      window_in = {window_ff[15:0], d};
      if (pos_ff < POS_LIMIT) begin
         pos_in = pos_ff + PW'(1);
      end

      // end of buffer: back to reset values
      if (req_last_byte) begin
         window_in = '0;
         pos_in    = '0;
         start_in  = '0;
         prefix_in = h264nal_pkg::PREFIX_NONE;
         header_in = '0;
         phase_in  = h264nal_pkg::PH_OPEN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         pos_ff    <= '0;
         start_ff  <= '0;
         prefix_ff <= h264nal_pkg::PREFIX_NONE;
         header_ff <= '0;
         phase_ff  <= h264nal_pkg::PH_OPEN;
      end else if (req_xfer) begin
         window_ff <= window_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         prefix_ff <= prefix_in;
         header_ff <= header_in;
         phase_ff  <= phase_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register: load on a byte that closes a unit or raises an error, drop once transferred
   // ---------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_xfer && fire) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_unit_offset   = rsp_ff.unit_offset;
   assign rsp_unit_length   = rsp_ff.unit_length;
   assign rsp_prefix_length = rsp_ff.prefix_length;
   assign rsp_zero_bit      = rsp_ff.zero_bit;
   assign rsp_ref_idc       = rsp_ff.ref_idc;
   assign rsp_unit_type     = rsp_ff.unit_type;
   assign rsp_error_kind    = rsp_ff.error_kind;
   assign rsp_end_of_buffer = rsp_ff.end_of_buffer;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_err_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.error_kind != h264nal_pkg::ERR_NONE)
      |-> rsp_ff.end_of_buffer && (rsp_ff.prefix_length == h264nal_pkg::PREFIX_NONE))
      else $error("error result without end_of_buffer or with a prefix");

   a_unit_prefix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.error_kind == h264nal_pkg::ERR_NONE)
      |-> (rsp_ff.prefix_length == h264nal_pkg::PREFIX_SHORT) ||
          (rsp_ff.prefix_length == h264nal_pkg::PREFIX_LONG))
      else $error("unit result with a bad prefix length");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_last_byte
      |=> (pos_ff == '0) && (phase_ff == h264nal_pkg::PH_OPEN))
      else $error("state not cleared after the last byte");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LIMIT)
      else $error("byte position past the buffer limit");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled result lost or changed");

endmodule
